### rtl/sfr_pkg.sv
package sfr_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE     = 2'd2;

    // Register reset values
    localparam logic [DATA_W-1:0] RST_PREAMBLE_FIRST  = 8'd170;
    localparam logic [DATA_W-1:0] RST_PREAMBLE_SECOND = 8'd85;
    localparam logic [DATA_W-1:0] RST_ESCAPE_CODE     = 8'd125;

    typedef enum logic [1:0] {
        ST_RECEIVE,
        ST_READ,
        ST_SHOW
    } t_rx_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic advance;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic frame_good;
        logic idx_last;
    } t_dp_status;

endpackage

### rtl/sfr_ctrl.sv
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    output logic       o_frame_valid,
    input  logic       i_frame_stall,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    t_rx_state r_state;
    t_rx_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RECEIVE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RECEIVE: begin
                if (i_rx_valid && i_status.frame_good) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (!i_frame_stall) begin
                    n_state = i_status.idx_last ? ST_RECEIVE : ST_READ;
                end
            end
            default: begin
                n_state = ST_RECEIVE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd         = '0;
        o_rx_stall    = 1'b1;
        o_frame_valid = 1'b0;
        unique case (r_state)
            ST_RECEIVE: begin
                o_rx_stall   = 1'b0;
                o_cmd.accept = i_rx_valid;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_SHOW: begin
                o_frame_valid = 1'b1;
                o_cmd.advance = !i_frame_stall && !i_status.idx_last;
            end
            default: begin
                o_rx_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/sfr_datapath.sv
module sfr_datapath
    import sfr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [DATA_W-1:0]    i_rx_byte,
    input  t_ctl_cmd             i_cmd,
    output t_dp_status           o_status,
    output logic [DATA_W-1:0]    o_frame_byte,
    output logic [IDX_W-1:0]     o_byte_index,
    output logic                 o_last
);

    localparam int unsigned CW = $clog2(PACKET_BYTES);
    localparam logic [CW-1:0] LAST_IDX = CW'(PACKET_BYTES - 1);

    logic [DATA_W-1:0] r_preamble_first;
    logic [DATA_W-1:0] r_preamble_second;
    logic [DATA_W-1:0] r_escape_code;

    logic [DATA_W-1:0] r_mem [PACKET_BYTES];
    logic [DATA_W-1:0] r_rd_data;
    logic [CW-1:0]     r_rd_idx;

    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_sum;
    logic              r_in_frame;
    logic              r_seen;
    logic              r_esc_pend;

    logic              is_first;
    logic              is_second;
    logic              is_data;
    logic              count_full;
    logic [DATA_W-1:0] sum_next;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_first  <= RST_PREAMBLE_FIRST;
            r_preamble_second <= RST_PREAMBLE_SECOND;
            r_escape_code     <= RST_ESCAPE_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PREAMBLE_FIRST:  r_preamble_first  <= i_cfg_data;
                REG_PREAMBLE_SECOND: r_preamble_second <= i_cfg_data;
                REG_ESCAPE_CODE:     r_escape_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the incoming byte; first preamble wins over second, then data
    assign is_first   = (i_rx_byte == r_preamble_first) && !r_esc_pend;
    assign is_second  = !is_first && (i_rx_byte == r_preamble_second)
                        && !r_esc_pend && r_seen;
    assign is_data    = !is_first && !is_second && r_in_frame
                        && ((i_rx_byte != r_escape_code) || r_esc_pend);
    assign count_full = (r_count == LAST_IDX);
    assign sum_next   = r_sum + i_rx_byte;

    assign o_status.frame_good = i_cmd.accept && is_data && count_full
                                 && (sum_next == '0);
    assign o_status.idx_last   = (r_rd_idx == LAST_IDX);

    // Frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_in_frame <= 1'b0;
            r_seen     <= 1'b0;
            r_esc_pend <= 1'b0;
        end else if (i_cmd.accept) begin
            r_esc_pend <= (i_rx_byte == r_escape_code) && !r_esc_pend;
            if (is_first) begin
                r_seen     <= 1'b1;
                r_in_frame <= 1'b0;
            end else if (is_second) begin
                r_in_frame <= 1'b1;
                r_count    <= '0;
                r_sum      <= '0;
            end else if (is_data) begin
                if (count_full) begin
                    r_count    <= '0;
                    r_sum      <= '0;
                    r_in_frame <= 1'b0;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= sum_next;
                end
            end
        end
    end

    // Frame store: write on data beats, registered read during readout
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_data) begin
            r_mem[r_count] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Readout index: rewind while receiving, advance per output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.accept) begin
            r_rd_idx <= '0;
        end else if (i_cmd.advance) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    assign o_frame_byte = r_rd_data;
    assign o_byte_index = IDX_W'(r_rd_idx);
    assign o_last       = o_status.idx_last;

endmodule

### rtl/stuffed_frame_receiver_top.sv
// Byte-stuffed frame receiver. Received bytes enter one per beat on the rx
// channel; a first preamble byte arms the receiver and aborts any open frame,
// a second preamble byte (once armed) opens a frame, and an escape byte makes
// the next byte literal. After PACKET_BYTES frame bytes, a frame whose
// modulo-256 byte sum is zero is sent out on the frame channel as
// PACKET_BYTES beats with byte_index and last; otherwise it is dropped.
// While receiving, the block takes one byte per clock. After a good frame the
// rx channel stalls through the readout, including any output stall: each
// output byte needs a registered read of the frame store (ST_READ) and then
// the output beat (ST_SHOW).
module stuffed_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [DATA_W-1:0]    i_rx_byte,
    output logic                 o_frame_valid,
    input  logic                 i_frame_stall,
    output logic [DATA_W-1:0]    o_frame_byte,
    output logic [IDX_W-1:0]     o_byte_index,
    output logic                 o_last
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    // Sequencing of receive and readout
    sfr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .o_frame_valid (o_frame_valid),
        .i_frame_stall (i_frame_stall),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Deframing, checksum and frame store
    sfr_datapath #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_rx_byte    (i_rx_byte),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_frame_byte (o_frame_byte),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

endmodule
